// ===== src/point_segment_distance_unit_defines.svh =====
// Assertion macros used by the port checker of the distance unit.
`ifndef POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH

// Checks a property at every clock edge, reset cycles included.
`define PSD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) else $error("psd check failed");

// Checks a property outside of reset.
`define PSD_ASSERT_RUN(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("psd check failed");

`endif

// ===== src/psd_pkg.sv =====
// Shared types and widths of the point to segment distance unit.
package psd_pkg;

   localparam int IN_W    = 32;
   localparam int DIFF_W  = 33;
   localparam int PROD_W  = 66;
   localparam int SUM_W   = 67;
   localparam int NUM_W   = 67;
   localparam int RAD_W   = 66;
   localparam int ROOT_W  = 34;
   localparam int DIST_W  = 33;
   localparam int REM_W   = 67;

   typedef enum logic [1:0] {
      KIND_BEYOND_END   = 2'd0,
      KIND_BEFORE_START = 2'd1,
      KIND_PERPENDICULAR = 2'd2,
      KIND_DEGENERATE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [NUM_W-1:0] num;
   } psd_tag_type;

endpackage

// ===== src/psd_sqrt.sv =====
// Pipelined floor square root, one result bit resolved per stage.
module psd_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  psd_pkg::psd_tag_type        in_tag,
   input  logic [psd_pkg::RAD_W-1:0]   in_rad,
   output logic                        out_valid,
   output psd_pkg::psd_tag_type        out_tag,
   output logic [psd_pkg::ROOT_W-1:0]  out_root
);
   import psd_pkg::*;

   logic              vld_ff  [ROOT_W];
   psd_tag_type       tag_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      localparam int K = ROOT_W - 1 - s;
      logic              prev_vld;
      psd_tag_type       prev_tag;
      logic [REM_W-1:0]  prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [69:0]       trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_tag  = in_tag;
         assign prev_rem  = {{(REM_W-RAD_W){1'b0}}, in_rad};
         assign prev_root = '0;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_tag  = tag_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_root = root_ff[s-1];
      end

      always_comb begin
         trial   = ({36'd0, prev_root} << (K + 1)) | (70'd1 << (2 * K));
         ge      = {3'd0, prev_rem} >= trial;
         rem_in  = ge ? prev_rem - trial[REM_W-1:0] : prev_rem;
         root_in = ge ? (prev_root | (ROOT_W'(1) << K)) : prev_root;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s]  <= prev_tag;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

// ===== src/psd_div.sv =====
// Pipelined saturating cross product/length divide, else root passed on.
module psd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  psd_pkg::psd_tag_type        in_tag,
   input  logic [psd_pkg::ROOT_W-1:0]  in_root,
   output logic                        out_valid,
   output psd_pkg::kind_type           out_kind,
   output logic [psd_pkg::DIST_W-1:0]  out_dist
);
   import psd_pkg::*;

   localparam int STEPS = DIST_W + 1;

   logic              vld_ff  [STEPS];
   kind_type          kind_ff [STEPS];
   logic [ROOT_W-1:0] root_ff [STEPS];
   logic [REM_W-1:0]  rem_ff  [STEPS];
   logic [DIST_W-1:0] quo_ff  [STEPS];
   logic              sat_ff  [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic              prev_vld;
      kind_type          prev_kind;
      logic [ROOT_W-1:0] prev_root;
      logic [REM_W-1:0]  prev_rem;
      logic [DIST_W-1:0] prev_quo;
      logic              prev_sat;
      logic [REM_W-1:0]  rem_in;
      logic [DIST_W-1:0] quo_in;
      logic              sat_in;

      if (s == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_kind = in_tag.kind;
         assign prev_root = in_root;
         assign prev_rem  = in_tag.num;
         assign prev_quo  = '0;
         assign prev_sat  = 1'b0;
         always_comb begin
            sat_in = prev_rem >= {in_root, {DIST_W{1'b0}}};
            rem_in = prev_rem;
            quo_in = prev_quo;
         end
      end else begin : g_next
         localparam int I = STEPS - 1 - s;
         logic [REM_W-1:0] trial;
         logic             ge;
         assign prev_vld  = vld_ff[s-1];
         assign prev_kind = kind_ff[s-1];
         assign prev_root = root_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_quo  = quo_ff[s-1];
         assign prev_sat  = sat_ff[s-1];
         always_comb begin
            trial  = {{(REM_W-ROOT_W){1'b0}}, prev_root} << I;
            ge     = prev_rem >= trial;
            rem_in = ge ? prev_rem - trial : prev_rem;
            quo_in = ge ? (prev_quo | (DIST_W'(1) << I)) : prev_quo;
            sat_in = prev_sat;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            kind_ff[s] <= prev_kind;
            root_ff[s] <= prev_root;
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            sat_ff[s]  <= sat_in;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_kind  = kind_ff[STEPS-1];
   always_comb begin
      if (kind_ff[STEPS-1] == KIND_PERPENDICULAR) begin
         out_dist = sat_ff[STEPS-1] ? {DIST_W{1'b1}} : quo_ff[STEPS-1];
      end else begin
         out_dist = root_ff[STEPS-1][DIST_W-1:0];
      end
   end

endmodule

// ===== src/point_segment_distance_unit.sv =====
// Top level of the point to segment distance unit.
//
// Takes one segment and query point per cycle and returns the truncated
// distance and the nearest-feature case: three stages form
// the differences, the products and the sums, 34 stages resolve the square
// root one bit each, and 34 more check saturation, then resolve the quotient
// one bit each. The last stage is the output register; when it holds a
// result that is not taken, the whole pipeline holds and req_tready drops.
module point_segment_distance_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, end_x, end_y, point_x, point_y
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dist_res, zero padding
   output logic [39:0]  rsp_tdata,
   // nearest_case
   output logic [1:0]   rsp_tuser
);
   import psd_pkg::*;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic signed [IN_W-1:0] ax, ay, bx, by, px, py;
   assign ax = req_tdata[31:0];
   assign ay = req_tdata[63:32];
   assign bx = req_tdata[95:64];
   assign by = req_tdata[127:96];
   assign px = req_tdata[159:128];
   assign py = req_tdata[191:160];

   logic                     v1_ff;
   logic signed [DIFF_W-1:0] abx_ff, aby_ff, bpx_ff, bpy_ff, apx_ff, apy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abx_ff <= {bx[IN_W-1], bx} - {ax[IN_W-1], ax};
         aby_ff <= {by[IN_W-1], by} - {ay[IN_W-1], ay};
         bpx_ff <= {px[IN_W-1], px} - {bx[IN_W-1], bx};
         bpy_ff <= {py[IN_W-1], py} - {by[IN_W-1], by};
         apx_ff <= {px[IN_W-1], px} - {ax[IN_W-1], ax};
         apy_ff <= {py[IN_W-1], py} - {ay[IN_W-1], ay};
      end
   end

   logic                     v2_ff, degen_ff;
   logic signed [PROD_W-1:0] db0_ff, db1_ff, da0_ff, da1_ff, cr0_ff, cr1_ff;
   logic signed [PROD_W-1:0] ab0_ff, ab1_ff, bp0_ff, bp1_ff, ap0_ff, ap1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         degen_ff <= (abx_ff == '0) && (aby_ff == '0);
         db0_ff   <= abx_ff * bpx_ff;
         db1_ff   <= aby_ff * bpy_ff;
         da0_ff   <= abx_ff * apx_ff;
         da1_ff   <= aby_ff * apy_ff;
         cr0_ff   <= abx_ff * apy_ff;
         cr1_ff   <= aby_ff * apx_ff;
         ab0_ff   <= abx_ff * abx_ff;
         ab1_ff   <= aby_ff * aby_ff;
         bp0_ff   <= bpx_ff * bpx_ff;
         bp1_ff   <= bpy_ff * bpy_ff;
         ap0_ff   <= apx_ff * apx_ff;
         ap1_ff   <= apy_ff * apy_ff;
      end
   end

   logic signed [SUM_W-1:0] dot_b, dot_a, cross_sum;
   logic [RAD_W-1:0]        len_sq, bp_sq, ap_sq;
   kind_type                kind_in;
   psd_tag_type             tag_in;
   logic [RAD_W-1:0]        rad_in;

   always_comb begin
      dot_b     = {db0_ff[PROD_W-1], db0_ff} + {db1_ff[PROD_W-1], db1_ff};
      dot_a     = {da0_ff[PROD_W-1], da0_ff} + {da1_ff[PROD_W-1], da1_ff};
      cross_sum = {cr0_ff[PROD_W-1], cr0_ff} - {cr1_ff[PROD_W-1], cr1_ff};
      len_sq    = ab0_ff + ab1_ff;
      bp_sq     = bp0_ff + bp1_ff;
      ap_sq     = ap0_ff + ap1_ff;
      if (degen_ff) begin
         kind_in = KIND_DEGENERATE;
         rad_in  = ap_sq;
      end else if (dot_b > 0) begin
         kind_in = KIND_BEYOND_END;
         rad_in  = bp_sq;
      end else if (dot_a < 0) begin
         kind_in = KIND_BEFORE_START;
         rad_in  = ap_sq;
      end else begin
         kind_in = KIND_PERPENDICULAR;
         rad_in  = len_sq;
      end
      tag_in.kind = kind_in;
      tag_in.num  = cross_sum[SUM_W-1] ? NUM_W'(-cross_sum) : NUM_W'(cross_sum);
   end

   logic             v3_ff;
   psd_tag_type      tag3_ff;
   logic [RAD_W-1:0] rad3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag3_ff <= tag_in;
         rad3_ff <= rad_in;
      end
   end

   logic              sq_valid;
   psd_tag_type       sq_tag;
   logic [ROOT_W-1:0] sq_root;

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (v3_ff),
      .in_tag    (tag3_ff),
      .in_rad    (rad3_ff),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .out_root  (sq_root)
   );

   kind_type          out_kind;
   logic [DIST_W-1:0] out_dist;

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (sq_valid),
      .in_tag    (sq_tag),
      .in_root   (sq_root),
      .out_valid (rsp_tvalid),
      .out_kind  (out_kind),
      .out_dist  (out_dist)
   );

   assign rsp_tdata = {7'd0, out_dist};
   assign rsp_tuser = out_kind;

endmodule

// ===== src/psd_checker.sv =====
// Port-level checks of the distance unit, bound to its top level.
`include "point_segment_distance_unit_defines.svh"

module psd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `PSD_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_tvalid)
   `PSD_ASSERT_RUN(a_ready_follows_output, req_tready == (!rsp_tvalid || rsp_tready))
   `PSD_ASSERT_RUN(a_pad_zero, rsp_tvalid |-> (rsp_tdata[39:33] == 7'd0))
   `PSD_ASSERT_RUN(a_stall_holds,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))

endmodule

bind point_segment_distance_unit psd_checker u_psd_checker (.*);
